@@ hdl/frc_pkg.sv @@
// frc_pkg: shared types, framing constants and beat packing for the frame receiver
// no dependencies; imported by every module of the block
package frc_pkg;

	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 9;
	localparam int TDATA_W  = 32;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [BYTE_W-1:0]  START_BYTE = 8'hAA;
	localparam logic [BYTE_W-1:0]  END_BYTE   = 8'hFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 9'd256;

	// register index, taken from paddr[2]
	localparam logic REG_ACK_TYPE = 1'b0;

	// m_tdata bit positions, lowest first
	localparam int TD_ECHO_LSB   = 0;
	localparam int TD_CSUM_OK    = 8;
	localparam int TD_KIND_LSB   = 9;
	localparam int TD_TAG_LSB    = 17;
	localparam int TD_RESYNC     = 25;
	localparam int TD_ACK_SEEN   = 26;
	localparam int TD_ACK_NEEDED = 27;
	localparam int TD_USED_W     = 28;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_echo;
		logic              is_payload;
		logic              frame_end;
		logic              checksum_ok;
		logic [BYTE_W-1:0] frame_kind;
		logic [BYTE_W-1:0] frame_tag;
		logic              resync;
		logic              ack_seen;
		logic              ack_needed;
	} res_t;

	function automatic logic [TDATA_W-1:0] pack_tdata(input res_t r);
		logic [TDATA_W-1:0] d;
		d = '0;
		d[TD_ECHO_LSB +: BYTE_W] = r.byte_echo;
		d[TD_CSUM_OK]            = r.checksum_ok;
		d[TD_KIND_LSB +: BYTE_W] = r.frame_kind;
		d[TD_TAG_LSB +: BYTE_W]  = r.frame_tag;
		d[TD_RESYNC]             = r.resync;
		d[TD_ACK_SEEN]           = r.ack_seen;
		d[TD_ACK_NEEDED]         = r.ack_needed;
		return d;
	endfunction

endpackage

@@ hdl/frc_track.sv @@
// frc_track: frame position tracking, field capture and checksum for one byte
// depends on frc_pkg
module frc_track (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [frc_pkg::BYTE_W-1:0] rx_byte,
	input  logic [frc_pkg::BYTE_W-1:0] ack_code,
	output frc_pkg::res_t             res
);
	import frc_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0]  length_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [BYTE_W-1:0]  check_q;
	logic [BYTE_W-1:0]  kind_q;
	logic [BYTE_W-1:0]  tag_q;

	logic [COUNT_W-1:0] count_nxt;
	logic [BYTE_W-1:0]  len;
	logic [BYTE_W-1:0]  sum_nxt;
	logic [BYTE_W-1:0]  check_nxt;
	logic [BYTE_W-1:0]  kind_nxt;
	logic [BYTE_W-1:0]  tag_nxt;
	logic [COUNT_W:0]   pos_w;
	logic [COUNT_W:0]   len_w;
	logic               started;
	logic               payload;
	logic               fend;
	logic               good;
	logic               rs;

	always_comb begin
		pos_w     = {1'b0, count_q};
		count_nxt = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;
		len       = (count_q == 9'd1) ? rx_byte : length_q;
		len_w     = {2'b00, len};
		started   = (count_q != '0);
		check_nxt = (started && (pos_w + 10'd2 == len_w)) ? rx_byte : check_q;
		kind_nxt  = (count_q == 9'd2) ? rx_byte : kind_q;
		tag_nxt   = (count_q == 9'd3) ? rx_byte : tag_q;
		payload   = (count_q >= 9'd4) && (pos_w + 10'd3 <= len_w);
		sum_nxt   = sum_q + rx_byte;
		fend      = started && (rx_byte == END_BYTE) && (count_nxt == {1'b0, len});
		good      = fend && ((sum_nxt - check_nxt) == check_nxt);
		rs        = started && !fend && (rx_byte == START_BYTE) && (count_nxt > {1'b0, len});

		res.byte_echo   = rx_byte;
		res.is_payload  = payload && !rs;
		res.frame_end   = fend;
		res.checksum_ok = good;
		res.frame_kind  = fend ? kind_nxt : '0;
		res.frame_tag   = fend ? tag_nxt : '0;
		res.resync      = rs;
		res.ack_seen    = good && (kind_nxt == ack_code);
		res.ack_needed  = good && (kind_nxt != ack_code);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			length_q <= '0;
			sum_q    <= '0;
			check_q  <= '0;
			kind_q   <= '0;
			tag_q    <= '0;
		end else if (en) begin
			if (rs) begin
				count_q  <= 9'd1;
				length_q <= '0;
				sum_q    <= START_BYTE;
				check_q  <= '0;
				kind_q   <= '0;
				tag_q    <= '0;
			end else begin
				count_q  <= count_nxt;
				length_q <= len;
				sum_q    <= sum_nxt;
				check_q  <= check_nxt;
				kind_q   <= kind_nxt;
				tag_q    <= tag_nxt;
			end
		end
	end

endmodule

@@ hdl/frc_out_reg.sv @@
// frc_out_reg: result register driving the master-side stream
// depends on frc_pkg
module frc_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  frc_pkg::res_t               res,
	output logic                        free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [frc_pkg::TDATA_W-1:0] m_tdata,   // echo, csum_ok, kind, tag, resync, ack_seen, ack_needed
	output logic                        m_tlast,   // frame_end
	output logic                        m_tuser    // is_payload
);
	import frc_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = pack_tdata(res_q);
	assign m_tlast  = res_q.frame_end;
	assign m_tuser  = res_q.is_payload;

endmodule

@@ hdl/frame_receiver_checksum_unit.sv @@
// frame_receiver_checksum_unit: top level of the byte-stream deframer with additive checksum
// depends on frc_pkg, frc_track, frc_out_reg
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------------
//  s_*      | in  | tdata[7:0] rx_byte
//  m_*      | out | tdata: echo, csum_ok, kind, tag, resync, ack_seen, ack_needed;
//           |     | tlast frame_end; tuser is_payload
//  apb      | cfg | reg 0 at 0x0: ack_type_code[7:0]
//
// one byte per cycle sustained while m_tready is high; an input beat reaches the output beat through
// the input register, then the tracking logic into the result register
// arst_n clears the frame state, the ack code and both valid flags
// a stalled m_tready holds the result; one more byte waits in the input register,
// then s_tready drops until the result is taken
module frame_receiver_checksum_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave-side stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [frc_pkg::BYTE_W-1:0]   s_tdata,   // rx_byte
	// master-side stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [frc_pkg::TDATA_W-1:0]  m_tdata,   // byte_echo[7:0], checksum_ok[8],
	                                                // frame_kind[16:9], frame_tag[24:17],
	                                                // resync[25], ack_seen[26], ack_needed[27]
	output logic                         m_tlast,   // frame_end
	output logic                         m_tuser,   // is_payload
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [frc_pkg::PADDR_W-1:0]  paddr,
	input  logic [frc_pkg::PDATA_W-1:0]  pwdata,
	output logic [frc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import frc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] ack_code_q;
	logic              out_free;
	logic              advance;
	res_t              res;

	// register select comes from the word address bit; byte offset bits are ignored
	logic reg_sel;
	assign reg_sel = paddr[2];

	// apb: zero wait state, write on the access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q <= '0;
		end else if (psel && penable && pwrite && pready && (reg_sel == REG_ACK_TYPE)) begin
			ack_code_q <= pwdata[BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == REG_ACK_TYPE) begin
			prdata[BYTE_W-1:0] = ack_code_q;
		end
	end

	// the byte in the input register moves on whenever the result register can take it
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// frame state advances exactly once per byte, when its result is captured
	frc_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.rx_byte  (byte_s1),
		.ack_code (ack_code_q),
		.res      (res)
	);

	frc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

@@ hdl/frc_checker.sv @@
// frc_checker: port-level checks on the master-side beats of the frame receiver
// depends on frc_pkg; bound to frame_receiver_checksum_unit below
module frc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [frc_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tlast,
	input logic                        m_tuser
);
	import frc_pkg::*;

	// a stalled beat keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled output beat changed");

	// a frame end is always the end byte and never a payload byte
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[TD_ECHO_LSB +: BYTE_W] == END_BYTE && !m_tuser)
		else $error("frame end on wrong byte");

	// checksum and ack flags only appear on a frame end
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[TD_CSUM_OK] || m_tdata[TD_ACK_SEEN] || m_tdata[TD_ACK_NEEDED])
			|-> m_tlast && m_tdata[TD_CSUM_OK])
		else $error("good-frame flags without frame end");

	// a good frame is either an ack or needs one, never both
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[TD_CSUM_OK] |-> m_tdata[TD_ACK_SEEN] != m_tdata[TD_ACK_NEEDED])
		else $error("ack flags inconsistent");

	// resync only on a start byte that is neither payload nor frame end
	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[TD_RESYNC]
			|-> m_tdata[TD_ECHO_LSB +: BYTE_W] == START_BYTE && !m_tlast && !m_tuser)
		else $error("resync on wrong byte");

endmodule

bind frame_receiver_checksum_unit frc_checker u_frc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
